// ===== design/ipxsr_pkg.sv =====
package ipxsr_pkg;

    localparam int SESSIONS_DEF = 16;
    localparam int SESSION_W    = 4;
    localparam int SOCKET_W     = 16;
    localparam int NODE_W       = 32;
    localparam int IN_DATA_W    = 120;
    localparam int OUT_DATA_W   = 40;

    localparam logic [NODE_W-1:0]   FIRST_NODE = 32'd9001;
    localparam logic [NODE_W-1:0]   BCAST_NODE = 32'hffff_ffff;
    localparam logic [NODE_W-1:0]   NULL_HOST  = 32'h0000_0000;
    localparam logic [SOCKET_W-1:0] REG_SOCKET = 16'h0002;

    typedef enum logic [1:0] {
        KIND_JOIN   = 2'd0,
        KIND_LEAVE  = 2'd1,
        KIND_PACKET = 2'd2
    } kind_e_t;

    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_ASSIGN  = 2'd1,
        ACT_REPLY   = 2'd2,
        ACT_DELIVER = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REPLY,
        ST_SCAN,
        ST_FLUSH,
        ST_EMIT
    } state_t;

    typedef struct packed {
        action_t                action;
        logic [SESSION_W-1:0]   target;
        logic [NODE_W-1:0]      node;
        logic                   last;
    } result_t;

    localparam result_t RES_NONE = '{action: ACT_NONE, target: '0, node: '0, last: 1'b1};

endpackage

// ===== design/ipx_session_router.sv =====
// Session router: session table with node allocator and packet routing.
//
// Input channel (s_*): one transaction per event. s_tuser carries the kind
// (join, leave, packet received); s_tdata carries the session slot and the
// packet header words. Output channel (m_*): one or more result transactions
// per event, m_tlast marks the final one. m_tuser carries the action code.
//
// Timing: s_tready is high only between events. Join, leave and packets from
// a free or unregistered slot go through ST_EMIT, a registration reply
// through ST_REPLY and then ST_EMIT. A packet from a registered slot scans
// the node memory one slot per cycle unless a result waits on the output,
// and a unicast stops early at its match; the node memory has a single read
// port. Each result is registered in the output register before it appears.
//
// Results sit in an output register; a scan step whose result finds it full,
// with m_tready low, holds at its slot until it frees up. Nothing is dropped.
// Reset clears every slot's in-use and registered flag and sets the next node
// number to 9001; no clearing pass is needed and the block accepts input in
// the first cycle after reset.
module ipx_session_router
    import ipxsr_pkg::*;
#(
    parameter int SESSIONS = SESSIONS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // session[3:0], dest_socket[19:4], dest_host[51:20], src_node[83:52],
    // dest_node[115:84], zero pad
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // kind[1:0]
    input  logic [1:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // target_session[3:0], node_number[35:4], zero pad
    output logic [OUT_DATA_W-1:0] m_tdata,
    // action[1:0]
    output logic [1:0]            m_tuser,
    output logic                  m_tlast
);

    localparam int IDX_W = $clog2(SESSIONS);

    logic              out_free;
    logic              push;
    result_t           res;
    logic              ram_wr_en;
    logic              ram_rd_en;
    logic [IDX_W-1:0]  ram_addr;
    logic [NODE_W-1:0] ram_wdata;
    logic [NODE_W-1:0] ram_rdata;

    ipxsr_ctrl #(
        .SESSIONS (SESSIONS)
    ) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .in_kind        (kind_e_t'(s_tuser)),
        .in_session     (s_tdata[3:0]),
        .in_dest_socket (s_tdata[19:4]),
        .in_dest_host   (s_tdata[51:20]),
        .in_src_node    (s_tdata[83:52]),
        .in_dest_node   (s_tdata[115:84]),
        .out_free       (out_free),
        .push           (push),
        .res            (res),
        .ram_wr_en      (ram_wr_en),
        .ram_rd_en      (ram_rd_en),
        .ram_addr       (ram_addr),
        .ram_wdata      (ram_wdata),
        .ram_rdata      (ram_rdata)
    );

    ipxsr_node_ram #(
        .SESSIONS (SESSIONS)
    ) u_node_ram (
        .aclk  (aclk),
        .wr_en (ram_wr_en),
        .rd_en (ram_rd_en),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    ipxsr_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .res      (res),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== design/ipxsr_node_ram.sv =====
module ipxsr_node_ram
    import ipxsr_pkg::*;
#(
    parameter int SESSIONS = SESSIONS_DEF
) (
    input  logic                          aclk,
    input  logic                          wr_en,
    input  logic                          rd_en,
    input  logic [$clog2(SESSIONS)-1:0]   addr,
    input  logic [NODE_W-1:0]             wdata,
    output logic [NODE_W-1:0]             rdata
);

    logic [NODE_W-1:0] mem [SESSIONS];
    logic [NODE_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= wdata;
        end
        if (rd_en) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/ipxsr_out_reg.sv =====
module ipxsr_out_reg
    import ipxsr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  result_t               res,
    output logic                  out_free,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [1:0]            m_tuser,
    output logic                  m_tlast
);

    logic    valid_reg;
    result_t res_reg;

    assign out_free = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (push) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {(OUT_DATA_W - NODE_W - SESSION_W)'(0), res_reg.node, res_reg.target};
    assign m_tuser  = res_reg.action;
    assign m_tlast  = res_reg.last;

endmodule

// ===== design/ipxsr_ctrl.sv =====
module ipxsr_ctrl
    import ipxsr_pkg::*;
#(
    parameter int SESSIONS = SESSIONS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  kind_e_t                       in_kind,
    input  logic [SESSION_W-1:0]          in_session,
    input  logic [SOCKET_W-1:0]           in_dest_socket,
    input  logic [NODE_W-1:0]             in_dest_host,
    input  logic [NODE_W-1:0]             in_src_node,
    input  logic [NODE_W-1:0]             in_dest_node,
    input  logic                          out_free,
    output logic                          push,
    output result_t                       res,
    output logic                          ram_wr_en,
    output logic                          ram_rd_en,
    output logic [$clog2(SESSIONS)-1:0]   ram_addr,
    output logic [NODE_W-1:0]             ram_wdata,
    input  logic [NODE_W-1:0]             ram_rdata
);

    localparam int IDX_W = $clog2(SESSIONS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SESSIONS - 1);

    state_t state_reg, state_next;

    logic [SESSIONS-1:0] in_use_reg;
    logic [SESSIONS-1:0] regd_reg;
    logic [NODE_W-1:0]   next_node_reg;

    logic [IDX_W-1:0]    idx_reg;
    logic [IDX_W-1:0]    slot_reg;
    logic                bcast_reg;
    logic [NODE_W-1:0]   src_node_reg;
    logic [NODE_W-1:0]   dest_node_reg;
    logic                held_valid_reg;
    logic [IDX_W-1:0]    held_idx_reg;
    logic [NODE_W-1:0]   held_node_reg;
    result_t             res_reg;

    logic             accept;
    logic [IDX_W-1:0] sidx;
    logic             in_range;
    logic             is_join;
    logic             is_leave;
    logic             pkt_live;
    logic             reg_req;
    logic             go_reply;
    logic             go_scan;

    logic             live;
    logic             send;
    logic             uni_hit;
    logic             need_push;
    logic             stall;

    // input decode
    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign sidx     = IDX_W'(in_session);
    assign in_range = (32'(in_session) < SESSIONS);
    assign is_join  = in_range && (in_kind == KIND_JOIN);
    assign is_leave = in_range && (in_kind == KIND_LEAVE);
    assign pkt_live = in_range && (in_kind == KIND_PACKET) && in_use_reg[sidx];
    assign reg_req  = (in_dest_socket == REG_SOCKET) && (in_dest_host == NULL_HOST);
    assign go_reply = pkt_live && !regd_reg[sidx] && reg_req;
    assign go_scan  = pkt_live && regd_reg[sidx];

    // scan step: ram_rdata holds the node of slot idx_reg
    assign live      = in_use_reg[idx_reg] && regd_reg[idx_reg];
    assign send      = live && (bcast_reg ? (ram_rdata != src_node_reg)
                                          : (ram_rdata == dest_node_reg));
    assign uni_hit   = send && !bcast_reg;
    assign need_push = uni_hit || (send && held_valid_reg);
    assign stall     = need_push && !out_free;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (go_reply) begin
                        state_next = ST_REPLY;
                    end else if (go_scan) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_REPLY: begin
                state_next = ST_EMIT;
            end
            ST_SCAN: begin
                if (!stall) begin
                    if (uni_hit) begin
                        state_next = ST_IDLE;
                    end else if (idx_reg == LAST_IDX) begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH, ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        push      = 1'b0;
        res       = RES_NONE;
        ram_wr_en = 1'b0;
        ram_rd_en = 1'b0;
        ram_addr  = sidx;
        ram_wdata = next_node_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    ram_wr_en = is_join;
                    ram_rd_en = go_reply || go_scan;
                    if (go_scan) begin
                        ram_addr = '0;
                    end
                end
            end
            ST_REPLY: begin
            end
            ST_SCAN: begin
                if (uni_hit) begin
                    push = out_free;
                    res  = '{action: ACT_DELIVER, target: SESSION_W'(idx_reg),
                             node: ram_rdata, last: 1'b1};
                end else if (send && held_valid_reg) begin
                    push = out_free;
                    res  = '{action: ACT_DELIVER, target: SESSION_W'(held_idx_reg),
                             node: held_node_reg, last: 1'b0};
                end
                // look ahead one slot unless this one waits on the output, ends a unicast or is the last
                ram_addr  = idx_reg + 1'b1;
                ram_rd_en = !stall && !uni_hit && (idx_reg != LAST_IDX);
            end
            ST_FLUSH: begin
                push = out_free;
                if (held_valid_reg) begin
                    res = '{action: ACT_DELIVER, target: SESSION_W'(held_idx_reg),
                            node: held_node_reg, last: 1'b1};
                end
            end
            ST_EMIT: begin
                push = out_free;
                res  = res_reg;
            end
            default: begin
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            in_use_reg     <= '0;
            regd_reg       <= '0;
            next_node_reg  <= FIRST_NODE;
            held_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                held_valid_reg <= 1'b0;
                if (is_join) begin
                    in_use_reg[sidx] <= 1'b1;
                    regd_reg[sidx]   <= 1'b0;
                    next_node_reg    <= next_node_reg + 1'b1;
                end else if (is_leave) begin
                    in_use_reg[sidx] <= 1'b0;
                    regd_reg[sidx]   <= 1'b0;
                end else if (go_reply) begin
                    regd_reg[sidx]   <= 1'b1;
                end
            end else if (state_reg == ST_SCAN && !stall && send && bcast_reg) begin
                held_valid_reg <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (accept) begin
            idx_reg       <= '0;
            slot_reg      <= sidx;
            bcast_reg     <= (in_dest_node == BCAST_NODE);
            src_node_reg  <= in_src_node;
            dest_node_reg <= in_dest_node;
            if (is_join) begin
                res_reg <= '{action: ACT_ASSIGN, target: in_session,
                             node: next_node_reg, last: 1'b1};
            end else begin
                res_reg <= RES_NONE;
            end
        end
        if (state_reg == ST_REPLY) begin
            res_reg <= '{action: ACT_REPLY, target: SESSION_W'(slot_reg),
                         node: ram_rdata, last: 1'b1};
        end
        if (state_reg == ST_SCAN && !stall) begin
            if (send && bcast_reg) begin
                held_idx_reg  <= idx_reg;
                held_node_reg <= ram_rdata;
            end
            if (idx_reg != LAST_IDX) begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

endmodule

// ===== design/ipxsr_checker.sv =====
module ipxsr_checker
    import ipxsr_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic [1:0]            m_tuser,
    input logic                  m_tlast
);

    // output register empties on reset
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // one event at a time: input closes right after a transaction
    a_one_event: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second event accepted while busy");

    // only deliveries come in runs
    a_single_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != ACT_DELIVER) |-> m_tlast)
        else $error("non-delivery result without tlast");

    a_none_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ACT_NONE) |-> (m_tdata == '0))
        else $error("empty result carries data");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind ipx_session_router ipxsr_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
